// ===== design/itc_pkg.sv =====
// ----------------------------------------------------------------------------
// itc_pkg
// shared types and constants of the ignition timing controller
// ----------------------------------------------------------------------------
package itc_pkg;

	localparam int HISTORY_DEPTH = 8;
	localparam int MAP_COUNT     = 4;
	localparam int MAP_COLUMNS   = 32;
	localparam int RPM_STEP      = 500;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// command codes
	localparam logic [2:0] CMD_TDC       = 3'd0;
	localparam logic [2:0] CMD_BDC       = 3'd1;
	localparam logic [2:0] CMD_PERIOD_OV = 3'd2;
	localparam logic [2:0] CMD_SPARK_OV  = 3'd3;
	localparam logic [2:0] CMD_MAP_WRITE = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CUT_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_END   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DYN_ON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DYN_OFF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_MAP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TPM       = 3'd6;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] ticks;
		logic [15:0] handler_delay;
		logic        immobilised;
		logic [1:0]  map_select;
		logic [4:0]  map_column;
		logic [7:0]  map_value;
	} in_item_t;

	typedef struct packed {
		logic               coil_on;
		logic               spark_load_valid;
		logic [15:0]        spark_timer_load;
		logic [15:0]        engine_rpm;
		logic signed [15:0] measured_advance;
		logic               rev_cut_active;
		logic               map_active;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HIST_RD,
		ST_HIST_SUM,
		ST_FILL,
		ST_MEAN,
		ST_BRANCH,
		ST_TDC_FLAGS,
		ST_TDC_MUL,
		ST_TDC_DIV,
		ST_TDC_FIN,
		ST_RPM_DIV,
		ST_RPM_FIN,
		ST_MAP_RD,
		ST_MAP_WAIT,
		ST_LOAD_MUL,
		ST_LOAD_DIV,
		ST_LOAD_FIN,
		ST_OUT
	} state_t;

endpackage

// ===== design/ignition_timing_controller.sv =====
// ----------------------------------------------------------------------------
// ignition_timing_controller
// crank event sequencer: history average, rpm, rev limit, advance map lookup
// ----------------------------------------------------------------------------
//
// channel   | direction | handshake      | payload
// ----------+-----------+----------------+-------------------------
// in        | input     | in_valid/ready | itc_pkg::in_item_t
// out       | output    | out_valid/ready| itc_pkg::out_item_t
// cfg       | input     | cfg_we         | cfg_index, cfg_data
//
// one transaction at a time; the time a crank edge takes from acceptance to the
// result is set by the history memory sweep and the 32-step serial divide of
// the measured advance (the rpm divide takes fewer steps); other commands go
// straight from acceptance to the output step.
// the history and map live in synchronous memories; after reset the history
// reads as zero through a fill mark (an edge while stopped rewrites all).
// a result waits in the output register; the next transaction is taken once
// the previous result has left.
module ignition_timing_controller #(
	parameter int HISTORY_DEPTH = itc_pkg::HISTORY_DEPTH,
	parameter int MAP_COUNT     = itc_pkg::MAP_COUNT,
	parameter int MAP_COLUMNS   = itc_pkg::MAP_COLUMNS,
	parameter int RPM_STEP      = itc_pkg::RPM_STEP
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  itc_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output itc_pkg::out_item_t               out_item,
	input  logic                             cfg_we,
	input  logic [itc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [itc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int MSW   = (MAP_COUNT > 1) ? $clog2(MAP_COUNT) : 1;
	localparam int MCW   = $clog2(MAP_COLUMNS);
	localparam int MAW   = MSW + MCW;
	localparam int SUMW  = 16 + HW + 1;
	localparam int HCW   = HW + 1;

	// reciprocal of 180, exact for products below 2^24
	localparam logic [24:0] RECIP_180   = 25'd23860930;
	localparam int          RECIP_SHIFT = 32;

	// configuration registers
	logic [15:0] cut_start_q, cut_end_q, dyn_on_q, dyn_off_q;
	logic [7:0]  base_adv_q;
	logic [1:0]  act_map_q;
	logic [23:0] tpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_start_q <= 16'd6000;
			cut_end_q   <= 16'd5800;
			dyn_on_q    <= 16'd1200;
			dyn_off_q   <= 16'd1000;
			base_adv_q  <= 8'd10;
			act_map_q   <= 2'd0;
			tpm_q       <= 24'd15000000;
		end else if (cfg_we) begin
			case (cfg_index)
				itc_pkg::REG_CUT_START: cut_start_q <= cfg_data[15:0];
				itc_pkg::REG_CUT_END:   cut_end_q   <= cfg_data[15:0];
				itc_pkg::REG_DYN_ON:    dyn_on_q    <= cfg_data[15:0];
				itc_pkg::REG_DYN_OFF:   dyn_off_q   <= cfg_data[15:0];
				itc_pkg::REG_BASE_ADV:  base_adv_q  <= cfg_data[7:0];
				itc_pkg::REG_ACT_MAP:   act_map_q   <= cfg_data[1:0];
				itc_pkg::REG_TPM:       tpm_q       <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// control and working registers
	itc_pkg::state_t state_q, state_d;
	itc_pkg::in_item_t in_q;
	itc_pkg::out_item_t out_q;
	logic        out_valid_q;
	logic        hist_init_q;            // history memory holds real data
	logic [HW-1:0]  slot_q;
	logic [HCW-1:0] cnt_q;
	logic [SUMW-1:0] sum_q;
	logic [15:0] mean_q, rpm_q, spark_tick_q, adv_q;
	logic signed [16:0] accel_q;
	logic        cut_q, dyn_q, coil_q;
	logic [3:0]  stopped_q;
	logic        valid_q;
	logic [15:0] load_q;
	logic [15:0] pu_q;
	// serial divider
	logic [31:0] dvd_q;
	logic [16:0] dvs_q;
	logic [32:0] rem_q;
	logic [5:0]  dcnt_q;
	logic        neg_q;
	logic [MCW-1:0] col_q;

	// memories
	logic [15:0] hist_mem [HISTORY_DEPTH];
	logic [7:0]  map_mem [MAP_COUNT*MAP_COLUMNS];
	logic        hist_we, map_we;
	logic [HW-1:0]  hist_addr;
	logic [15:0]    hist_wdata, hist_rdata;
	logic [MAW-1:0] map_waddr, map_raddr;
	logic [MAW-1:0] map_base;
	logic [7:0]     map_rdata;

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_addr] <= hist_wdata;
		hist_rdata <= hist_mem[hist_addr];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= in_q.map_value;
		map_rdata <= map_mem[map_raddr];
	end

	assign in_ready  = (state_q == itc_pkg::ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	wire accept = in_valid && in_ready;
	wire last_sweep = (cnt_q == HCW'(HISTORY_DEPTH - 1));
	wire [HW-1:0] next_slot = (slot_q == HW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	wire [HW-1:0] cnt_addr  = cnt_q[HW-1:0];

	// restoring divider step
	wire [32:0] rem_sh = {rem_q[31:0], dvd_q[31]};
	wire [32:0] rem_sub = rem_sh - {16'd0, dvs_q};
	wire        div_ok = !rem_sub[32];
	wire        div_done = (dcnt_q == 6'd32);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			itc_pkg::ST_IDLE: if (accept) begin
				if (in_item.cmd == itc_pkg::CMD_TDC || in_item.cmd == itc_pkg::CMD_BDC)
					state_d = itc_pkg::ST_HIST_RD;
				else
					state_d = itc_pkg::ST_OUT;
			end
			itc_pkg::ST_HIST_RD:
				state_d = (mean_q == 16'd0) ? itc_pkg::ST_FILL : itc_pkg::ST_HIST_SUM;
			itc_pkg::ST_FILL:     if (last_sweep) state_d = itc_pkg::ST_BRANCH;
			itc_pkg::ST_HIST_SUM: if (last_sweep) state_d = itc_pkg::ST_MEAN;
			itc_pkg::ST_MEAN:     state_d = itc_pkg::ST_BRANCH;
			itc_pkg::ST_BRANCH:
				state_d = (in_q.cmd == itc_pkg::CMD_TDC) ? itc_pkg::ST_TDC_FLAGS :
					(mean_q == 16'd0) ? itc_pkg::ST_OUT : itc_pkg::ST_RPM_DIV;
			itc_pkg::ST_TDC_FLAGS: state_d = itc_pkg::ST_TDC_MUL;
			itc_pkg::ST_TDC_MUL:
				state_d = (!cut_q && dyn_q && mean_q != 16'd0) ? itc_pkg::ST_TDC_DIV
					: itc_pkg::ST_TDC_FIN;
			itc_pkg::ST_TDC_DIV:  if (div_done) state_d = itc_pkg::ST_TDC_FIN;
			itc_pkg::ST_TDC_FIN:  state_d = itc_pkg::ST_OUT;
			itc_pkg::ST_RPM_DIV:  if (div_done) state_d = itc_pkg::ST_RPM_FIN;
			itc_pkg::ST_RPM_FIN:  state_d = itc_pkg::ST_MAP_RD;
			itc_pkg::ST_MAP_RD:
				state_d = (cut_q || rpm_q == 16'd0 || in_q.immobilised) ? itc_pkg::ST_OUT
					: itc_pkg::ST_MAP_WAIT;
			itc_pkg::ST_MAP_WAIT: state_d = itc_pkg::ST_LOAD_MUL;
			itc_pkg::ST_LOAD_MUL:
				state_d = (dyn_q && map_rdata > base_adv_q) ? itc_pkg::ST_LOAD_DIV
					: itc_pkg::ST_LOAD_FIN;
			itc_pkg::ST_LOAD_DIV: state_d = itc_pkg::ST_LOAD_FIN;
			itc_pkg::ST_LOAD_FIN: state_d = itc_pkg::ST_OUT;
			itc_pkg::ST_OUT:      state_d = itc_pkg::ST_IDLE;
			default:              state_d = itc_pkg::ST_IDLE;
		endcase
	end

	// first entry of the active map, map number folded into the map count
	always_comb begin
		int am;
		am = int'(act_map_q);
		for (int k = 0; k < 3; k++)
			if (am >= MAP_COUNT) am = am - MAP_COUNT;
		map_base = MAW'(am * MAP_COLUMNS);
	end

	// memory port control
	always_comb begin
		hist_we    = 1'b0;
		hist_addr  = cnt_addr;
		hist_wdata = in_q.ticks;
		map_we     = 1'b0;
		map_waddr  = MAW'({in_q.map_select, in_q.map_column});
		map_raddr  = map_base + MAW'(col_q);
		case (state_q)
			itc_pkg::ST_HIST_RD: begin
				hist_we   = 1'b1;
				hist_addr = next_slot;
			end
			itc_pkg::ST_FILL: hist_we = 1'b1;
			itc_pkg::ST_OUT: begin
				map_we = (in_q.cmd == itc_pkg::CMD_MAP_WRITE)
					&& (32'(in_q.map_select) < MAP_COUNT)
					&& (32'(in_q.map_column) < MAP_COLUMNS);
				map_waddr = MAW'(in_q.map_select) * MAW'(MAP_COLUMNS) + MAW'(in_q.map_column);
			end
			default: ;
		endcase
	end

	// rpm column from rpm, step by step reciprocal-free compare
	logic [MCW-1:0] col_calc;
	always_comb begin
		col_calc = '0;
		for (int j = 1; j < MAP_COLUMNS; j++)
			if (32'(rpm_q) >= 32'(j * RPM_STEP)) col_calc = MCW'(j);
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= itc_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			hist_init_q  <= 1'b0;
			slot_q       <= '0;
			mean_q       <= '0;
			accel_q      <= '0;
			rpm_q        <= '0;
			cut_q        <= 1'b0;
			dyn_q        <= 1'b0;
			coil_q       <= 1'b0;
			stopped_q    <= '0;
			spark_tick_q <= '0;
			adv_q        <= '0;
			dcnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				itc_pkg::ST_IDLE: if (accept) begin
					in_q    <= in_item;
					valid_q <= 1'b0;
					load_q  <= '0;
					cnt_q   <= '0;
					sum_q   <= '0;
					if (in_item.cmd == itc_pkg::CMD_TDC && coil_q) begin
						coil_q       <= 1'b0;
						spark_tick_q <= in_item.ticks;
					end
				end
				itc_pkg::ST_HIST_RD: begin
					slot_q <= next_slot;
					cnt_q  <= '0;
				end
				itc_pkg::ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_sweep) begin
						hist_init_q <= 1'b1;
						stopped_q   <= '0;
						mean_q      <= in_q.ticks;
					end
				end
				itc_pkg::ST_HIST_SUM: begin
					// read data follows its address in the next cycle
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != '0) sum_q <= sum_q + SUMW'(hist_init_q ? hist_rdata : 16'd0);
				end
				itc_pkg::ST_MEAN: begin
					logic [SUMW-1:0] s;
					s = sum_q + SUMW'(hist_init_q ? hist_rdata : 16'd0);
					mean_q  <= 16'(s / HISTORY_DEPTH);
					accel_q <= $signed({1'b0, mean_q}) - $signed({1'b0, 16'(s / HISTORY_DEPTH)});
				end
				itc_pkg::ST_TDC_FLAGS: begin
					if (rpm_q > cut_start_q && !cut_q) cut_q <= 1'b1;
					else if (cut_q && rpm_q < cut_end_q) cut_q <= 1'b0;
					if (rpm_q > dyn_on_q && !dyn_q) dyn_q <= 1'b1;
					else if (rpm_q < dyn_off_q && dyn_q) dyn_q <= 1'b0;
				end
				itc_pkg::ST_TDC_MUL: begin
					logic signed [16:0] diff;
					logic signed [25:0] prod;
					diff = $signed({1'b0, mean_q}) - $signed({1'b0, spark_tick_q});
					prod = diff * 26'sd180;
					neg_q  <= prod[25];
					dvd_q  <= 32'(prod[25] ? -prod : prod);
					dvs_q  <= {1'b0, mean_q};
					rem_q  <= '0;
					dcnt_q <= '0;
				end
				itc_pkg::ST_TDC_DIV, itc_pkg::ST_RPM_DIV: begin
					if (!div_done) begin
						rem_q  <= div_ok ? rem_sub : rem_sh;
						dvd_q  <= {dvd_q[30:0], div_ok};
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				itc_pkg::ST_TDC_FIN: begin
					logic signed [26:0] a;
					logic signed [26:0] q;
					a = $signed({19'd0, base_adv_q});
					q = $signed({2'b0, dvd_q[24:0]});
					if (!cut_q && dyn_q && mean_q != 16'd0)
						a = a + (neg_q ? -q : q);
					adv_q <= (a > 27'sd32767) ? 16'h7fff : (a < -27'sd32768) ? 16'h8000
						: a[15:0];
					valid_q <= 1'b1;
				end
				itc_pkg::ST_BRANCH: if (in_q.cmd == itc_pkg::CMD_BDC && mean_q != 16'd0) begin
					dvd_q  <= {tpm_q, 8'd0};
					dvs_q  <= {1'b0, mean_q};
					rem_q  <= '0;
					dcnt_q <= 6'd8;
				end
				itc_pkg::ST_RPM_FIN: begin
					// quotient of the 24-bit count, halved and saturated
					rpm_q <= (dvd_q[23:17] != '0) ? 16'hffff : dvd_q[16:1];
				end
				itc_pkg::ST_MAP_RD: col_q <= col_calc;
				itc_pkg::ST_LOAD_MUL: begin
					logic signed [18:0] p;
					logic [15:0] pu;
					p  = $signed({2'b0, mean_q}) + $signed({{2{accel_q[16]}}, accel_q});
					pu = p[18] ? 16'd0 : (p[17:16] != 2'b0) ? 16'hffff : p[15:0];
					pu_q  <= pu;
					dvd_q <= 32'(pu) * 32'(map_rdata - base_adv_q);
				end
				itc_pkg::ST_LOAD_DIV: begin
					// divide by 180 through the reciprocal
					logic [48:0] rq;
					rq = 49'(dvd_q[23:0]) * 49'(RECIP_180);
					dvd_q <= 32'(rq[48:RECIP_SHIFT]);
				end
				itc_pkg::ST_LOAD_FIN: begin
					logic [15:0] l;
					l = (dyn_q && map_rdata > base_adv_q) ? 16'hffff - pu_q + dvd_q[15:0] : 16'd0;
					load_q  <= l + in_q.handler_delay;
					coil_q  <= 1'b1;
					valid_q <= 1'b1;
				end
				itc_pkg::ST_OUT: begin
					case (in_q.cmd)
						itc_pkg::CMD_PERIOD_OV: begin
							if (stopped_q < 4'd15) stopped_q <= stopped_q + 1'b1;
							if (stopped_q >= 4'd10) coil_q <= 1'b0;
							mean_q <= '0;
							rpm_q  <= '0;
							cut_q  <= 1'b0;
						end
						itc_pkg::CMD_SPARK_OV: if (mean_q != 16'd0 && !cut_q && !in_q.immobilised) begin
							coil_q       <= 1'b0;
							spark_tick_q <= in_q.ticks;
						end
						default: ;
					endcase
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register, taken from the state as it stands after the command
	always_ff @(posedge clk) begin
		if (state_q == itc_pkg::ST_OUT) begin
			out_q.coil_on          <= (in_q.cmd == itc_pkg::CMD_PERIOD_OV && stopped_q >= 4'd10)
				|| (in_q.cmd == itc_pkg::CMD_SPARK_OV && mean_q != 16'd0 && !cut_q
				&& !in_q.immobilised) ? 1'b0 : coil_q;
			out_q.spark_load_valid <= valid_q;
			out_q.spark_timer_load <= valid_q ? load_q : 16'd0;
			out_q.engine_rpm       <= (in_q.cmd == itc_pkg::CMD_PERIOD_OV) ? 16'd0 : rpm_q;
			out_q.measured_advance <= adv_q;
			out_q.rev_cut_active   <= (in_q.cmd == itc_pkg::CMD_PERIOD_OV) ? 1'b0 : cut_q;
			out_q.map_active       <= dyn_q;
		end
	end

	// assertions
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != itc_pkg::ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_out_after_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == itc_pkg::ST_OUT)
		else $error("result raised outside output step");
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.spark_load_valid) |-> (out_q.spark_timer_load == 16'd0))
		else $error("load without valid");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= 6'd32)
		else $error("divider overrun");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ignition timing controller: crank, overflow and
// map write transactions go through a queue-fed driver, an internal model of
// history averaging, rpm, rev limit and advance lookup predicts every result,
// and a monitor compares each output transaction field by field
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 80;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	itc_pkg::in_item_t              in_item = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	itc_pkg::out_item_t             out_item;
	logic                           cfg_we = 1'b0;
	logic [itc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [itc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// pending stimulus and predicted results
	itc_pkg::in_item_t  crank_events[$];
	itc_pkg::out_item_t predicted_reports[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit long_hold_req = 0;
	int hold_left = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	// model copy of the registers
	logic [15:0] m_cut_start, m_cut_end, m_dyn_on, m_dyn_off;
	logic [7:0]  m_base_adv;
	logic [1:0]  m_act_map;
	logic [23:0] m_tpm;

	// model copy of the state
	logic [15:0] m_hist[itc_pkg::HISTORY_DEPTH];
	logic [2:0]  m_slot;
	logic [15:0] m_mean;
	int          m_accel;
	logic [15:0] m_rpm;
	bit          m_cut, m_dyn, m_coil;
	int          m_stopped;
	logic [15:0] m_spark_tick;
	logic [15:0] m_adv;
	logic [7:0]  m_map[itc_pkg::MAP_COUNT*itc_pkg::MAP_COLUMNS];

	ignition_timing_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// half rotation history and running mean
	function automatic void log_half_period(input logic [15:0] t);
		int sum;
		int old;
		sum = 0;
		m_slot = m_slot + 3'd1;
		m_hist[m_slot] = t;
		if (m_mean == 0) begin
			m_stopped = 0;
			m_mean = t;
			for (int i = 0; i < itc_pkg::HISTORY_DEPTH; i++) m_hist[i] = t;
		end else begin
			old = int'(m_mean);
			for (int i = 0; i < itc_pkg::HISTORY_DEPTH; i++) sum += int'(m_hist[i]);
			m_mean = 16'(sum / itc_pkg::HISTORY_DEPTH);
			m_accel = old - int'(m_mean);
		end
	endfunction

	// top dead centre: coil off, hysteresis, measured advance
	function automatic void crank_tdc(input logic [15:0] t);
		int adv;
		int diff;
		if (m_coil) begin
			m_coil = 0;
			m_spark_tick = t;
		end
		log_half_period(t);
		if (m_rpm > m_cut_start && !m_cut) m_cut = 1;
		else if (m_cut && m_rpm < m_cut_end) m_cut = 0;
		if (m_rpm > m_dyn_on && !m_dyn) m_dyn = 1;
		else if (m_rpm < m_dyn_off && m_dyn) m_dyn = 0;
		adv = int'(m_base_adv);
		if (!m_cut && m_dyn && m_mean != 0) begin
			diff = int'(m_mean) - int'(m_spark_tick);
			adv += (180 * diff) / int'(m_mean);
		end
		if (adv > 32767) adv = 32767;
		if (adv < -32768) adv = -32768;
		m_adv = adv[15:0];
	endfunction

	// bottom dead centre: rpm, map lookup, spark load
	function automatic bit crank_bdc(input logic [15:0] t, input logic [15:0] dly,
			input logic immo, output logic [15:0] load);
		longint r;
		int col, v, p, tmp;
		int load16;
		load = '0;
		load16 = 0;
		log_half_period(t);
		if (m_mean == 0) return 0;
		r = (longint'(m_tpm) / longint'(m_mean)) >> 1;
		m_rpm = (r > 65535) ? 16'hFFFF : 16'(r);
		if (m_cut || m_rpm == 0 || immo) return 0;
		if (m_dyn) begin
			col = int'(m_rpm) / itc_pkg::RPM_STEP;
			if (col > itc_pkg::MAP_COLUMNS - 1) col = itc_pkg::MAP_COLUMNS - 1;
			v = int'(m_map[int'(m_act_map) * itc_pkg::MAP_COLUMNS + col]);
			if (v > int'(m_base_adv)) begin
				p = int'(m_mean) + m_accel;
				if (p < 0) p = 0;
				if (p > 65535) p = 65535;
				tmp = (p * (v - int'(m_base_adv))) / 180;
				load16 = (65535 - p + tmp) & 16'hFFFF;
			end
		end
		m_coil = 1;
		load = 16'(load16 + int'(dly));
		return 1;
	endfunction

	// expected result of one input transaction
	function automatic itc_pkg::out_item_t ignition_report(input itc_pkg::in_item_t it);
		itc_pkg::out_item_t r;
		bit valid;
		logic [15:0] load;
		valid = 0;
		load = '0;
		case (it.cmd)
			itc_pkg::CMD_TDC: begin
				crank_tdc(it.ticks);
				valid = 1;
			end
			itc_pkg::CMD_BDC:
				valid = crank_bdc(it.ticks, it.handler_delay, it.immobilised, load);
			itc_pkg::CMD_PERIOD_OV: begin
				if (m_stopped < 15) m_stopped++;
				if (m_stopped > 10) m_coil = 0;
				m_mean = 0;
				m_rpm = 0;
				m_cut = 0;
			end
			itc_pkg::CMD_SPARK_OV: begin
				if (m_mean != 0 && !m_cut && !it.immobilised) begin
					m_coil = 0;
					m_spark_tick = it.ticks;
				end
			end
			itc_pkg::CMD_MAP_WRITE:
				m_map[int'(it.map_select) * itc_pkg::MAP_COLUMNS + int'(it.map_column)] =
					it.map_value;
			default: ;
		endcase
		r.coil_on = m_coil;
		r.spark_load_valid = valid;
		r.spark_timer_load = valid ? load : 16'h0;
		r.engine_rpm = m_rpm;
		r.measured_advance = m_adv;
		r.rev_cut_active = m_cut;
		r.map_active = m_dyn;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predicted_reports.push_back(ignition_report(in_item));
			if (!in_valid || in_ready) begin
				if (crank_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= crank_events.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		itc_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", out_item);
				end else begin
					want = predicted_reports.pop_front();
					if (want.coil_on !== out_item.coil_on ||
							want.spark_load_valid !== out_item.spark_load_valid ||
							want.spark_timer_load !== out_item.spark_timer_load ||
							want.engine_rpm !== out_item.engine_rpm ||
							want.measured_advance !== out_item.measured_advance ||
							want.rev_cut_active !== out_item.rev_cut_active ||
							want.map_active !== out_item.map_active) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch coil %b/%b valid %b/%b load %h/%h rpm %0d/%0d",
								" adv %0d/%0d cut %b/%b map %b/%b (expected/actual)"},
								want.coil_on, out_item.coil_on,
								want.spark_load_valid, out_item.spark_load_valid,
								want.spark_timer_load, out_item.spark_timer_load,
								want.engine_rpm, out_item.engine_rpm,
								want.measured_advance, out_item.measured_advance,
								want.rev_cut_active, out_item.rev_cut_active,
								want.map_active, out_item.map_active);
					end
				end
			end
			if (long_hold_req) begin
				hold_left = 400;
				long_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic write_reg(input logic [itc_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[itc_pkg::CFG_DATA_W-1:0];
		case (idx)
			itc_pkg::REG_CUT_START: m_cut_start = val[15:0];
			itc_pkg::REG_CUT_END:   m_cut_end = val[15:0];
			itc_pkg::REG_DYN_ON:    m_dyn_on = val[15:0];
			itc_pkg::REG_DYN_OFF:   m_dyn_off = val[15:0];
			itc_pkg::REG_BASE_ADV:  m_base_adv = val[7:0];
			itc_pkg::REG_ACT_MAP:   m_act_map = val[1:0];
			itc_pkg::REG_TPM:       m_tpm = val[23:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int cs, input int ce, input int don, input int doff,
			input int base, input int amap, input int tpm);
		write_reg(itc_pkg::REG_CUT_START, cs);
		write_reg(itc_pkg::REG_CUT_END, ce);
		write_reg(itc_pkg::REG_DYN_ON, don);
		write_reg(itc_pkg::REG_DYN_OFF, doff);
		write_reg(itc_pkg::REG_BASE_ADV, base);
		write_reg(itc_pkg::REG_ACT_MAP, amap);
		write_reg(itc_pkg::REG_TPM, tpm);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every transaction has been answered, then let the block settle
	task automatic drain();
		while (crank_events.size() > 0 || in_valid || predicted_reports.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic itc_pkg::in_item_t any_event();
		itc_pkg::in_item_t it;
		it.cmd = 3'($urandom_range(0, 7));
		it.ticks = 16'($urandom);
		it.handler_delay = 16'($urandom);
		it.immobilised = 1'($urandom);
		it.map_select = 2'($urandom);
		it.map_column = 5'($urandom);
		it.map_value = 8'($urandom_range(0, 180));
		return it;
	endfunction

	function automatic itc_pkg::in_item_t crank_event(input logic [2:0] c, input int t,
			input int dly, input bit immo);
		itc_pkg::in_item_t it;
		it = any_event();
		it.cmd = c;
		it.ticks = 16'(t);
		it.handler_delay = 16'(dly);
		it.immobilised = immo;
		return it;
	endfunction

	// running engine traffic: alternating edges with drifting speed, plus noise
	task automatic queue_engine_run(input int n);
		int made, pick, half, burst;
		bit bdc_next;
		itc_pkg::in_item_t it;
		made = 0;
		bdc_next = 0;
		half = $urandom_range(500, 20000);
		while (made < n) begin
			pick = $urandom_range(0, 99);
			it = any_event();
			if (pick < 70) begin
				half += $urandom_range(0, 400) - 200;
				if (half < 300) half = 300;
				if (half > 30000) half = 30000;
				it.cmd = bdc_next ? itc_pkg::CMD_BDC : itc_pkg::CMD_TDC;
				bdc_next = !bdc_next;
				it.ticks = 16'(half + $urandom_range(0, 100) - 50);
				it.handler_delay = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 200));
				it.immobilised = ($urandom_range(0, 19) == 0);
			end else if (pick < 80) begin
				it.cmd = itc_pkg::CMD_SPARK_OV;
				it.ticks = 16'($urandom_range(0, half));
				it.immobilised = ($urandom_range(0, 9) == 0);
			end else if (pick < 85) begin
				it.cmd = itc_pkg::CMD_MAP_WRITE;
			end else if (pick < 90) begin
				burst = $urandom_range(1, 14);
				for (int i = 1; i < burst; i++) begin
					crank_events.push_back(crank_event(itc_pkg::CMD_PERIOD_OV, $urandom,
						$urandom, 0));
					made++;
				end
				it.cmd = itc_pkg::CMD_PERIOD_OV;
				half = $urandom_range(300, 20000);
			end else if (pick < 93) begin
				it.cmd = bdc_next ? itc_pkg::CMD_BDC : itc_pkg::CMD_TDC;
				bdc_next = !bdc_next;
				case ($urandom_range(0, 3))
					0: it.ticks = 16'h0;
					1: it.ticks = 16'hFFFF;
					2: it.ticks = 16'($urandom_range(1, 127));
					default: ;
				endcase
			end else if (pick < 96) begin
				half = $urandom_range(300, 30000);
				continue;
			end else begin
				it.cmd = 3'($urandom_range(5, 7));
			end
			crank_events.push_back(it);
			made++;
		end
	endtask

	initial begin
		itc_pkg::in_item_t it;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		m_slot = 0; m_mean = 0; m_accel = 0; m_rpm = 0;
		m_cut = 0; m_dyn = 0; m_coil = 0; m_stopped = 0;
		m_spark_tick = 0; m_adv = 0;
		for (int i = 0; i < itc_pkg::HISTORY_DEPTH; i++) m_hist[i] = '0;
		for (int i = 0; i < itc_pkg::MAP_COUNT * itc_pkg::MAP_COLUMNS; i++) m_map[i] = '0;

		// phase one: defaults, no idling
		set_regs(6000, 5800, 1200, 1000, 10, 0, 15000000);
		// fill every map entry so no lookup reads an unwritten cell
		for (int i = 0; i < itc_pkg::MAP_COUNT * itc_pkg::MAP_COLUMNS; i++) begin
			it = any_event();
			it.cmd = itc_pkg::CMD_MAP_WRITE;
			it.map_select = 2'(i / itc_pkg::MAP_COLUMNS);
			it.map_column = 5'(i % itc_pkg::MAP_COLUMNS);
			it.map_value = (i % 17 == 0) ? 8'd180 : (i % 19 == 0) ? 8'd0 :
				8'($urandom_range(0, 180));
			crank_events.push_back(it);
		end
		// directed events
		crank_events.push_back(crank_event(itc_pkg::CMD_SPARK_OV, 100, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_BDC, 0, 5, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_TDC, 2000, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_BDC, 2000, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_TDC, 2000, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_BDC, 2000, 40, 1));
		crank_events.push_back(crank_event(itc_pkg::CMD_BDC, 1900, 65535, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_SPARK_OV, 1500, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_TDC, 65535, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_BDC, 65535, 65535, 0));
		crank_events.push_back(crank_event(3'd5, 0, 0, 0));
		crank_events.push_back(crank_event(3'd6, 65535, 65535, 1));
		crank_events.push_back(crank_event(3'd7, 1, 1, 0));
		for (int i = 0; i < 12; i++)
			crank_events.push_back(crank_event(itc_pkg::CMD_PERIOD_OV, 0, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_TDC, 1250, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_BDC, 1000, 10, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_TDC, 1000, 0, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_BDC, 1000, 10, 0));
		crank_events.push_back(crank_event(itc_pkg::CMD_TDC, 1000, 0, 0));
		queue_engine_run(200);
		// receiver holds off while the sender keeps offering
		while (crank_events.size() > 150) @(posedge clk);
		long_hold_req = 1;
		queue_engine_run(250);
		drain();

		// phase two: upper extremes, sender idling
		send_idle_pct = 81;
		set_regs(65535, 0, 0, 0, 0, 3, 16777215);
		queue_engine_run(450);
		drain();

		// phase three: lower extremes, receiver stalling
		send_idle_pct = 0;
		recv_stall_pct = 81;
		set_regs(0, 65535, 65535, 65535, 180, 1, 1);
		queue_engine_run(250);
		drain();
		set_regs(7000, 3000, 2000, 1500, 180, 2, 16777215);
		queue_engine_run(200);
		drain();

		// phase four: both sides idling
		send_idle_pct = 29;
		recv_stall_pct = 29;
		set_regs(9000, 8000, 800, 600, 25, 2, 12000000);
		queue_engine_run(450);
		drain();

		if (mismatches == 0 && predicted_reports.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
